### src/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int LINK_W     = IDX_W + 1;
   localparam int BYTES_W    = 13;
   localparam int ADDR_W     = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES  = 2'd0,
      CSR_CHUNK_BLOCKS = 2'd1,
      CSR_ARENA_BLOCKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_FIN  = 2'b10
   } state_type;

endpackage

### src/fbpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request latch, allocation control,
// result register and configuration registers. Depends on fbpa_pkg and fbpa_ram.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one request: allocate (req_op = 0) or free (req_op = 1) with
//   req_free_is_null and req_free_index. A transfer takes place when req_valid is
//   high and req_stall is low. rsp_* returns one result per request in order:
//   rsp_granted, rsp_block_index, rsp_byte_address, rsp_chunk_count.
//   csr_* writes block_bytes (index 0), chunk_blocks (1) and arena_blocks (2);
//   csr_ready is always high. Write only while no request is in flight.
//   Order: a free loads the result register straight from the request latch, an
//   allocation passes through S_FIN first. The request latch holds one request
//   and raises req_stall while full; it frees up once it hands its request to
//   the control, so a new request can enter while an allocation is in S_FIN; a
//   free-list pop reads the link memory, whose registered read data is used in S_FIN.
//   While rsp_stall is high the result register holds, one request may wait in
//   the latch and req_stall rises.
//   Reset empties the free list, clears the chunk counters, loads the register
//   reset values (16, 64, 1024) and drops any request or result in flight. The
//   link memory is not cleared; a link is only read after a free has written it.

module fixed_block_pool_allocator
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic                  req_free_is_null,
   input  logic [IDX_W-1:0]      req_free_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_granted,
   output logic [IDX_W-1:0]      rsp_block_index,
   output logic [ADDR_W-1:0]     rsp_byte_address,
   output logic [CNT_W-1:0]      rsp_chunk_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type            state_ff, state_in;
   logic                 in_full_ff, in_full_in;
   logic                 in_op_ff, in_null_ff;
   logic [IDX_W-1:0]     in_idx_ff;
   link_type             head_ff, head_in;
   logic [CNT_W-1:0]     fresh_next_ff, fresh_next_in;
   logic [CNT_W-1:0]     fresh_left_ff, fresh_left_in;
   logic [CNT_W-1:0]     arena_used_ff, arena_used_in;
   logic [CNT_W-1:0]     chunks_done_ff, chunks_done_in;
   logic [BYTES_W-1:0]   block_bytes_ff;
   logic [CNT_W-1:0]     chunk_blocks_ff;
   logic [CNT_W-1:0]     arena_blocks_ff;
   logic                 pop_ff, pop_in;
   logic                 grant_ff, grant_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic                 out_free;
   logic                 go;
   logic                 push;
   logic                 load_free;
   logic                 load_fin;
   logic                 rd_en;
   logic [LINK_W-1:0]    rd_data;
   link_type             rd_link;
   logic [CNT_W-1:0]     cap;
   logic [CNT_W:0]       claim_sum;
   logic                 claim_ok;
   logic [IDX_W+BYTES_W-1:0] product;

   assign csr_ready = 1'b1;
   assign req_stall = in_full_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign go        = in_full_ff && (state_ff == S_IDLE) && ((in_op_ff == OP_ALLOC) || out_free);
   assign push      = go && (in_op_ff == OP_FREE) && !in_null_ff
                      && ({1'b0, in_idx_ff} < CNT_W'(MAX_BLOCKS));
   assign load_free = go && (in_op_ff == OP_FREE);
   assign load_fin  = (state_ff == S_FIN) && out_free;
   assign rd_en     = go && (in_op_ff == OP_ALLOC) && head_ff.valid;
   assign rd_link   = link_type'(rd_data);

   assign cap       = (arena_blocks_ff > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : arena_blocks_ff;
   assign claim_sum = {1'b0, arena_used_ff} + {1'b0, chunk_blocks_ff};
   assign claim_ok  = (chunk_blocks_ff != '0) && (claim_sum <= {1'b0, cap});
   assign product   = {{BYTES_W{1'b0}}, idx_ff} * {{IDX_W{1'b0}}, block_bytes_ff};

   fbpa_ram #(
      .WIDTH(LINK_W),
      .DEPTH(MAX_BLOCKS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(in_idx_ff),
      .wr_data(LINK_W'(head_ff)),
      .rd_en  (rd_en),
      .rd_addr(head_ff.idx),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      in_full_in     = in_full_ff;
      head_in        = head_ff;
      fresh_next_in  = fresh_next_ff;
      fresh_left_in  = fresh_left_ff;
      arena_used_in  = arena_used_ff;
      chunks_done_in = chunks_done_ff;
      pop_in         = pop_ff;
      grant_in       = grant_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (req_valid && !req_stall) begin
         in_full_in = 1'b1;
      end else if (go) begin
         in_full_in = 1'b0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_free || load_fin) begin
         rsp_valid_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (push) begin
               head_in = '{valid: 1'b1, idx: in_idx_ff};
            end
            if (go && (in_op_ff == OP_ALLOC)) begin
               state_in = S_FIN;
               priority if (head_ff.valid) begin
                  pop_in   = 1'b1;
                  grant_in = 1'b1;
                  idx_in   = head_ff.idx;
               end else if (fresh_left_ff != '0) begin
                  pop_in        = 1'b0;
                  grant_in      = 1'b1;
                  idx_in        = fresh_next_ff[IDX_W-1:0];
                  fresh_next_in = fresh_next_ff + 1'b1;
                  fresh_left_in = fresh_left_ff - 1'b1;
               end else if (claim_ok) begin
                  pop_in         = 1'b0;
                  grant_in       = 1'b1;
                  idx_in         = arena_used_ff[IDX_W-1:0];
                  fresh_next_in  = arena_used_ff + 1'b1;
                  fresh_left_in  = chunk_blocks_ff - 1'b1;
                  arena_used_in  = claim_sum[CNT_W-1:0];
                  chunks_done_in = chunks_done_ff + 1'b1;
               end else begin
                  pop_in   = 1'b0;
                  grant_in = 1'b0;
                  idx_in   = '0;
               end
            end
         end
         S_FIN: begin
            if (load_fin) begin
               state_in = S_IDLE;
               if (pop_ff) begin
                  head_in = rd_link;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         in_full_ff      <= 1'b0;
         head_ff         <= '0;
         fresh_next_ff   <= '0;
         fresh_left_ff   <= '0;
         arena_used_ff   <= '0;
         chunks_done_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         block_bytes_ff  <= BYTES_W'(16);
         chunk_blocks_ff <= CNT_W'(64);
         arena_blocks_ff <= CNT_W'(1024);
      end else begin
         state_ff       <= state_in;
         in_full_ff     <= in_full_in;
         head_ff        <= head_in;
         fresh_next_ff  <= fresh_next_in;
         fresh_left_ff  <= fresh_left_in;
         arena_used_ff  <= arena_used_in;
         chunks_done_ff <= chunks_done_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BLOCK_BYTES:  block_bytes_ff  <= csr_data[BYTES_W-1:0];
               CSR_CHUNK_BLOCKS: chunk_blocks_ff <= csr_data[CNT_W-1:0];
               CSR_ARENA_BLOCKS: arena_blocks_ff <= csr_data[CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff   <= req_op;
         in_null_ff <= req_free_is_null;
         in_idx_ff  <= req_free_index;
      end
      pop_ff   <= pop_in;
      grant_ff <= grant_in;
      idx_ff   <= idx_in;
      if (load_free) begin
         rsp_granted_ff <= 1'b1;
         rsp_index_ff   <= '0;
         rsp_addr_ff    <= '0;
         rsp_count_ff   <= chunks_done_ff;
      end else if (load_fin) begin
         rsp_granted_ff <= grant_ff;
         rsp_index_ff   <= idx_ff;
         rsp_addr_ff    <= product[ADDR_W-1:0];
         rsp_count_ff   <= chunks_done_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_block_index  = rsp_index_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_chunk_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_arena_bound: assert property (@(posedge clock) disable iff (reset)
      arena_used_ff <= CNT_W'(MAX_BLOCKS))
      else $error("arena usage beyond capacity");

   a_fresh_in_chunk: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fresh_next_ff} + {1'b0, fresh_left_ff}) <= {1'b0, arena_used_ff}
      && (fresh_left_ff == '0 || chunks_done_ff != '0))
      else $error("fresh blocks outside the claimed arena");

   a_denied_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> rsp_index_ff == '0 && rsp_addr_ff == '0)
      else $error("denied allocation carries an index");

   a_no_claim_no_use: assert property (@(posedge clock) disable iff (reset)
      chunks_done_ff == '0 |-> arena_used_ff == '0)
      else $error("arena used without a chunk");

   a_pop_follows_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == S_FIN && pop_ff)
      else $error("link read without a pop in progress");
`endif

endmodule

### bench/fixed_block_pool_allocator_tb.sv
// Self-checking bench for fixed_block_pool_allocator: directed and random alloc/free
// traffic, checked against a shadow free list. Depends on fbpa_pkg and the RTL in src.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic              granted;
      logic [IDX_W-1:0]  block_index;
      logic [ADDR_W-1:0] byte_address;
      logic [CNT_W-1:0]  chunk_count;
   } grant_type;

   class pool_shadow;
      logic [BYTES_W-1:0] block_bytes;
      logic [CNT_W-1:0]   chunk_blocks;
      logic [CNT_W-1:0]   arena_blocks;
      link_type           head;
      link_type           links [MAX_BLOCKS];
      logic [CNT_W-1:0]   fresh_next;
      logic [CNT_W-1:0]   fresh_left;
      logic [CNT_W-1:0]   arena_used;
      logic [CNT_W-1:0]   chunks_done;
      grant_type          pending [$];
      logic [IDX_W-1:0]   held [$];
      bit                 touched [MAX_BLOCKS];
      int                 mismatches;

      function new();
         block_bytes  = 16;
         chunk_blocks = 64;
         arena_blocks = 1024;
         head         = '0;
         fresh_next   = '0;
         fresh_left   = '0;
         arena_used   = '0;
         chunks_done  = '0;
         mismatches   = 0;
      endfunction

      function void set_reg(csr_index_type which, logic [CSR_DATA_W-1:0] value);
         case (which)
            CSR_BLOCK_BYTES:  block_bytes  = value[BYTES_W-1:0];
            CSR_CHUNK_BLOCKS: chunk_blocks = value[CNT_W-1:0];
            CSR_ARENA_BLOCKS: arena_blocks = value[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic op, logic is_null, logic [IDX_W-1:0] free_index);
         grant_type        g;
         logic [CNT_W-1:0] cap;
         logic [31:0]      product;
         int               k;
         g = '0;
         if (op == OP_FREE) begin
            if (!is_null) begin
               links[free_index]   = head;
               head                = {1'b1, free_index};
               touched[free_index] = 1'b1;
               for (k = 0; k < held.size(); k++) begin
                  if (held[k] == free_index) begin
                     held.delete(k);
                     break;
                  end
               end
            end
            g.granted = 1'b1;
         end else begin
            if (head.valid) begin
               g.block_index = head.idx;
               g.granted     = 1'b1;
               head          = links[head.idx];
            end else begin
               cap = (arena_blocks > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : arena_blocks;
               if (fresh_left == 0 && chunk_blocks != 0 && arena_used <= cap &&
                   chunk_blocks <= cap - arena_used) begin
                  fresh_next  = arena_used;
                  fresh_left  = chunk_blocks;
                  arena_used  = arena_used + chunk_blocks;
                  chunks_done = chunks_done + 1'b1;
               end
               if (fresh_left != 0) begin
                  g.block_index = fresh_next[IDX_W-1:0];
                  g.granted     = 1'b1;
                  fresh_next    = fresh_next + 1'b1;
                  fresh_left    = fresh_left - 1'b1;
               end
            end
            if (g.granted) begin
               product        = 32'(g.block_index) * 32'(block_bytes);
               g.byte_address = product[ADDR_W-1:0];
               held.push_back(g.block_index);
               touched[g.block_index] = 1'b1;
            end
         end
         g.chunk_count = chunks_done;
         pending.push_back(g);
      endfunction

      function void check_answer(grant_type got);
         grant_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: granted=%0d index=%0d addr=%0d chunks=%0d",
                        got.granted, got.block_index, got.byte_address, got.chunk_count);
            return;
         end
         want = pending.pop_front();
         if (got.granted !== want.granted || got.block_index !== want.block_index ||
             got.byte_address !== want.byte_address ||
             got.chunk_count !== want.chunk_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch at %0t: expected granted=%0d index=%0d addr=%0d ",
                         "chunks=%0d, got granted=%0d index=%0d addr=%0d chunks=%0d"},
                        $time, want.granted, want.block_index, want.byte_address,
                        want.chunk_count, got.granted, got.block_index, got.byte_address,
                        got.chunk_count);
         end
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_op           = OP_ALLOC;
   logic                  req_free_is_null = 1'b0;
   logic [IDX_W-1:0]      req_free_index   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic                  rsp_granted;
   logic [IDX_W-1:0]      rsp_block_index;
   logic [ADDR_W-1:0]     rsp_byte_address;
   logic [CNT_W-1:0]      rsp_chunk_count;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_BLOCK_BYTES;
   logic [CSR_DATA_W-1:0] csr_data         = '0;

   pool_shadow shadow;
   logic       calm       = 1'b0;
   logic       hold_req   = 1'b0;
   logic       hold_done  = 1'b0;
   int         hold_left  = 0;
   int         quiet_cycles = 0;

   fixed_block_pool_allocator dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_answer({rsp_granted, rsp_block_index, rsp_byte_address,
                              rsp_chunk_count});
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic op, logic is_null, logic [IDX_W-1:0] free_index);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_free_is_null <= is_null;
      req_free_index   <= free_index;
      do @(posedge clock); while (req_stall);
      shadow.note_request(op, is_null, free_index);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_alloc();
      send_request(OP_ALLOC, 1'($urandom), IDX_W'($urandom));
   endtask

   task automatic write_reg(csr_index_type which, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow.set_reg(which, value);
   endtask

   // drain, then load all three registers
   task automatic configure(logic [CSR_DATA_W-1:0] bytes_value,
                            logic [CSR_DATA_W-1:0] chunk_value,
                            logic [CSR_DATA_W-1:0] arena_value);
      req_valid <= 1'b0;
      while (shadow.pending.size() != 0) @(posedge clock);
      write_reg(CSR_BLOCK_BYTES, bytes_value);
      write_reg(CSR_CHUNK_BLOCKS, chunk_value);
      write_reg(CSR_ARENA_BLOCKS, arena_value);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count);
      int               pick;
      int               slot;
      logic [IDX_W-1:0] candidate;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick >= 50 && pick < 85 && shadow.held.size() != 0) begin
            slot      = $urandom_range(0, shadow.held.size() - 1);
            candidate = shadow.held[slot];
            send_request(OP_FREE, 1'b0, candidate);
         end else if (pick >= 85 && pick < 93) begin
            send_request(OP_FREE, 1'b1, IDX_W'($urandom));
         end else if (pick >= 93) begin
            // foreign block from the top range, never carved before the last phase
            candidate = IDX_W'($urandom_range(960, 1023));
            if (!shadow.touched[candidate])
               send_request(OP_FREE, 1'b0, candidate);
            else
               send_alloc();
         end else begin
            send_alloc();
         end
      end
   endtask

   initial begin
      logic [CNT_W-1:0] start_chunks;
      shadow = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      configure(13'd4096, 13'd1, 13'd3);
      send_request(OP_ALLOC, 1'b1, 10'd1023);
      send_request(OP_ALLOC, 1'b0, 10'd0);
      send_request(OP_ALLOC, 1'b1, 10'd512);
      send_alloc();
      send_request(OP_FREE, 1'b1, 10'd1023);
      send_request(OP_FREE, 1'b0, 10'd1023);
      send_request(OP_FREE, 1'b0, 10'd0);
      send_alloc();
      send_alloc();
      send_alloc();

      configure(13'd16, 13'd0, 13'd1024);
      send_alloc();
      configure(13'd4096, 13'd5, 13'd0);
      send_alloc();
      send_request(OP_FREE, 1'b1, 10'd0);

      configure(13'd16, 13'd1, 13'd64);
      run_random(250);

      configure(13'($urandom_range(1, 256) * 16), 13'($urandom_range(2, 16)), 13'd400);
      hold_req <= 1'b1;
      run_random(250);

      configure(13'd4096, 13'd64, 13'd700);
      calm <= 1'b1;
      run_random(250);
      calm <= 1'b0;

      configure(13'($urandom_range(1, 256) * 16), 13'd1024, 13'd1024);
      run_random(250);

      configure(13'd48, 13'($urandom_range(1, 40)), 13'd900);
      run_random(250);

      configure(13'd2032, 13'd0, 13'd2047);
      run_random(250);

      // claim exactly the rest of an oversized arena
      configure(13'd16, 13'(1024 - shadow.arena_used), 13'd2047);
      start_chunks = shadow.chunks_done;
      for (int n = 0; n < 1200 && shadow.chunks_done == start_chunks; n++)
         send_alloc();
      send_alloc();

      // double free last: it closes the free list on itself
      send_request(OP_FREE, 1'b0, 10'd5);
      send_request(OP_FREE, 1'b0, 10'd5);
      send_alloc();
      send_alloc();
      send_alloc();
      req_valid <= 1'b0;

      while (shadow.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
